>>> rtl/hst_pkg.sv
// Shared types, codes and defaults for the handle/socket table.
package hst_pkg;

	// Parameter defaults
	localparam int ENTRIES_DEF     = 64;
	localparam int KEY_BYTES_DEF   = 8;
	localparam int SOCKET_BITS_DEF = 16;

	// Port field widths
	localparam int CMD_W    = 3;
	localparam int KEY_W    = 64;
	localparam int LEN_W    = 4;
	localparam int SOCK_W_P = 16;
	localparam int IDX_W    = 6;
	localparam int STAT_W   = 2;
	localparam int SLOT_W   = 6;
	localparam int COUNT_W  = 7;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_REG  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REL  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LOOK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RDH  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RDO  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CNT  = 3'd5;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	// Token handed from cell to cell: the command plus its result so far
	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [KEY_W-1:0]    key;
		logic [LEN_W-1:0]    len;
		logic [SOCK_W_P-1:0] sock;
		logic [IDX_W-1:0]    idx;
		logic                done;
		logic                append;
		logic [STAT_W-1:0]   status;
		logic [SLOT_W-1:0]   slot;
		logic [SOCK_W_P-1:0] sock_out;
		logic [KEY_W-1:0]    key_out;
		logic [LEN_W-1:0]    len_out;
	} tok_t;

endpackage

>>> rtl/hst_cell.sv
// One table entry: stores a key, length, socket and active mark, and serves the passing token.
module hst_cell import hst_pkg::*; #(
	parameter int INDEX    = 0,
	parameter int KEY_BITS = 64,
	parameter int SOCK_W   = 16,
	parameter int CNT_W    = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [CNT_W-1:0] used_count,
	input  logic             prev_valid,
	input  tok_t             prev_tok,
	output logic             next_valid,
	output tok_t             next_tok
);

	localparam logic [SLOT_W-1:0] SLOT = SLOT_W'(INDEX);

	logic [KEY_BITS-1:0] key_q;
	logic [LEN_W-1:0]    len_q;
	logic [SOCK_W-1:0]   sock_q;
	logic                act_q;

	logic below, at_tail, at_idx, key_hit, sock_hit;
	logic wr, clr;
	tok_t tok_d;

	assign below    = INDEX < int'(used_count);
	assign at_tail  = INDEX == int'(used_count);
	assign at_idx   = INDEX == int'(prev_tok.idx);
	assign key_hit  = below && (key_q == prev_tok.key[KEY_BITS-1:0]);
	assign sock_hit = below && act_q && (sock_q == prev_tok.sock[SOCK_W-1:0]);

	always_comb begin
		tok_d = prev_tok;
		wr    = 1'b0;
		clr   = 1'b0;
		if (prev_valid && !prev_tok.done) begin
			unique case (prev_tok.cmd)
				CMD_REG: begin
					if (key_hit) begin
						tok_d.done = 1'b1;
						if (!act_q) begin
							wr           = 1'b1;
							tok_d.status = ST_OK;
							tok_d.slot   = SLOT;
						end
					end else if (at_tail) begin
						wr           = 1'b1;
						tok_d.done   = 1'b1;
						tok_d.append = 1'b1;
						tok_d.status = ST_OK;
						tok_d.slot   = SLOT;
					end
				end
				CMD_REL: begin
					if (sock_hit) begin
						clr          = 1'b1;
						tok_d.done   = 1'b1;
						tok_d.status = ST_OK;
					end
				end
				CMD_LOOK: begin
					if (key_hit) begin
						tok_d.done = 1'b1;
						if (act_q) begin
							tok_d.status   = ST_OK;
							tok_d.sock_out = SOCK_W_P'(sock_q);
						end
					end
				end
				CMD_RDH: begin
					if (at_idx) begin
						tok_d.done = 1'b1;
						if (!below) begin
							tok_d.status = ST_RANGE;
						end else if (act_q) begin
							tok_d.status  = ST_OK;
							tok_d.key_out = KEY_W'(key_q);
							tok_d.len_out = len_q;
						end
					end
				end
				CMD_RDO: begin
					if (at_idx) begin
						tok_d.done = 1'b1;
						if (!below) begin
							tok_d.status = ST_RANGE;
						end else if (act_q && (key_q != prev_tok.key[KEY_BITS-1:0])) begin
							tok_d.status   = ST_OK;
							tok_d.sock_out = SOCK_W_P'(sock_q);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Entry storage: undefined until written, only read below the fill count
	always_ff @(posedge clk) begin
		if (advance && wr) begin
			key_q  <= prev_tok.key[KEY_BITS-1:0];
			len_q  <= prev_tok.len;
			sock_q <= prev_tok.sock[SOCK_W-1:0];
			act_q  <= 1'b1;
		end else if (advance && clr) begin
			act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_valid <= 1'b0;
		end else if (advance) begin
			next_valid <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			next_tok <= tok_d;
		end
	end

endmodule

>>> rtl/handle_socket_table_top.sv
// Top level of the handle/socket table: input stage, row of entry cells, result stage.
// A command passes the input register, each entry cell in turn and the result register.
// One command at a time; the token moves one cell a cycle unless the result stage stalls.
// in_stall stays high from acceptance until the result is in the output register.
// Reset clears fill count, active count and all valid flags; entry storage is not reset.
// No clearing pass: entries at or above the fill count are never read.
module handle_socket_table_top import hst_pkg::*; #(
	parameter int ENTRIES     = ENTRIES_DEF,
	parameter int KEY_BYTES   = KEY_BYTES_DEF,
	parameter int SOCKET_BITS = SOCKET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// command channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [KEY_W-1:0]    handle,
	input  logic [LEN_W-1:0]    handle_length,
	input  logic [SOCK_W_P-1:0] socket,
	input  logic [IDX_W-1:0]    index,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STAT_W-1:0]   status,
	output logic [SLOT_W-1:0]   slot,
	output logic [SOCK_W_P-1:0] socket_out,
	output logic [KEY_W-1:0]    handle_out,
	output logic [LEN_W-1:0]    length_out,
	output logic [COUNT_W-1:0]  active_count
);

	localparam int KEY_BITS = 8 * KEY_BYTES;
	localparam int SOCK_W   = (SOCKET_BITS < SOCK_W_P) ? SOCKET_BITS : SOCK_W_P;
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam logic [KEY_W-1:0]    KEY_MASK  = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
	localparam logic [SOCK_W_P-1:0] SOCK_MASK = {SOCK_W_P{1'b1}} >> (SOCK_W_P - SOCK_W);

	// Control state
	logic             busy_q;     // a command is in the chain
	logic             out_valid_q;
	logic [CNT_W-1:0] used_q;     // entries appended so far
	logic [CNT_W-1:0] live_q;     // entries currently active

	// Chain: position 0 is the input register, position ENTRIES the tail
	logic [ENTRIES:0] chain_valid;
	tok_t             chain_tok [ENTRIES+1];

	logic accept, advance, load;
	tok_t in_tok_d, res;
	logic [COUNT_W-1:0] cnt_d;

	assign accept   = in_valid && !busy_q;
	assign in_stall = busy_q;

	// The whole row moves together; it only halts when the tail cannot unload
	assign load    = chain_valid[ENTRIES] && (!out_valid_q || !out_stall);
	assign advance = !(chain_valid[ENTRIES] && out_valid_q && out_stall);

	// Incoming beat, masked to the configured key and socket widths
	always_comb begin
		in_tok_d          = '0;
		in_tok_d.cmd      = cmd;
		in_tok_d.key      = handle & KEY_MASK;
		in_tok_d.len      = handle_length;
		in_tok_d.sock     = socket & SOCK_MASK;
		in_tok_d.idx      = index;
		in_tok_d.status   = ST_MISS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_valid[0] <= 1'b0;
		end else if (accept) begin
			chain_valid[0] <= 1'b1;
		end else if (advance) begin
			chain_valid[0] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chain_tok[0] <= in_tok_d;
		end
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		hst_cell #(
			.INDEX    (g),
			.KEY_BITS (KEY_BITS),
			.SOCK_W   (SOCK_W),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (advance),
			.used_count (used_q),
			.prev_valid (chain_valid[g]),
			.prev_tok   (chain_tok[g]),
			.next_valid (chain_valid[g+1]),
			.next_tok   (chain_tok[g+1])
		);
	end

	// Tail resolution: a token no cell claimed gets its command's fallback answer
	always_comb begin
		res   = chain_tok[ENTRIES];
		cnt_d = '0;
		if (!res.done) begin
			unique case (res.cmd) inside
				CMD_REG:          res.status = ST_FULL;
				CMD_RDH, CMD_RDO: res.status = ST_RANGE;
				CMD_CNT: begin
					res.status = ST_OK;
					cnt_d      = COUNT_W'(live_q);
				end
				default:          res.status = ST_MISS;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			used_q      <= '0;
			live_q      <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// Counts follow the beat as it leaves the chain
			if (load && res.done && (res.status == ST_OK)) begin
				if (res.cmd == CMD_REG) begin
					live_q <= live_q + 1'b1;
					if (res.append) begin
						used_q <= used_q + 1'b1;
					end
				end else if (res.cmd == CMD_REL) begin
					live_q <= live_q - 1'b1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load) begin
			status       <= res.status;
			slot         <= res.slot;
			socket_out   <= res.sock_out;
			handle_out   <= res.key_out;
			length_out   <= res.len_out;
			active_count <= cnt_d;
		end
	end

	assign out_valid = out_valid_q;

	// Checks
	a_live_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= used_q)
		else $error("active count above fill count");

	a_used_cap: assert property (@(posedge clk) disable iff (!arst_n)
		int'(used_q) <= ENTRIES)
		else $error("fill count beyond table size");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(chain_valid) <= 1)
		else $error("more than one command in the cell row");

	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_valid != '0) |-> busy_q)
		else $error("command in the row while idle");

	a_append_step: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res.done && res.append) |=> (used_q == $past(used_q) + 1'b1))
		else $error("append did not advance the fill count");

endmodule
